// ===== design/vbd_pkg.sv =====
// ----------------------------------------------------------------------------
// vbd_pkg
// Shared codes for the voxel box draw unit: command codes and the state
// encoding of the back-end sequencer.
// ----------------------------------------------------------------------------
package vbd_pkg;

   // Command carried by every input beat.
   typedef enum logic {
      CMD_DRAW = 1'b0,
      CMD_READ = 1'b1
   } vbd_cmd_code_type;

   // Back-end sequencer states.
   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_WALK = 1'b1
   } vbd_back_state_type;

endpackage

// ===== design/vbd_front.sv =====
// ----------------------------------------------------------------------------
// vbd_front
// Front end: clamps the coordinates, sorts each corner pair of a draw and
// builds the x span mask and x end mask, then pushes the packed command.
// ----------------------------------------------------------------------------
module vbd_front #(
   parameter int CUBE_SIZE = 8
) (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_cmd,
   input  logic [2:0]           req_x_first,
   input  logic [2:0]           req_y_first,
   input  logic [2:0]           req_z_first,
   input  logic [2:0]           req_x_second,
   input  logic [2:0]           req_y_second,
   input  logic [2:0]           req_z_second,
   input  logic                 req_solid,
   input  logic                 req_light,
   input  logic                 q_full,
   output logic                 q_push,
   output logic [3+4*$clog2(CUBE_SIZE)+2*CUBE_SIZE-1:0] q_data
);

   localparam int CW   = $clog2(CUBE_SIZE);
   localparam int W    = CUBE_SIZE;
   localparam int CMPW = (CW > 3) ? CW : 3;

   typedef struct packed {
      vbd_pkg::vbd_cmd_code_type cmd;
      logic                      solid;
      logic                      light;
      logic [CW-1:0]             y_lo;
      logic [CW-1:0]             y_hi;
      logic [CW-1:0]             z_lo;
      logic [CW-1:0]             z_hi;
      logic [W-1:0]              x_mask;
      logic [W-1:0]              end_mask;
   } vbd_cmd_type;

   // Coordinates beyond the cube saturate to the last plane.
   function automatic logic [CW-1:0] clamp_coord(input logic [2:0] v);
      logic [CMPW-1:0] ext;
      begin
         ext = CMPW'(v);
         if (ext > CMPW'(CUBE_SIZE - 1)) begin
            clamp_coord = CW'(CUBE_SIZE - 1);
         end else begin
            clamp_coord = CW'(ext);
         end
      end
   endfunction

   logic [CW-1:0] xa, ya, za, xb, yb, zb;
   logic [CW-1:0] x_lo, x_hi;
   vbd_cmd_type   cmd_word;

   assign xa = clamp_coord(req_x_first);
   assign ya = clamp_coord(req_y_first);
   assign za = clamp_coord(req_z_first);
   assign xb = clamp_coord(req_x_second);
   assign yb = clamp_coord(req_y_second);
   assign zb = clamp_coord(req_z_second);

   assign x_lo = (xa <= xb) ? xa : xb;
   assign x_hi = (xa <= xb) ? xb : xa;

   always_comb begin
      cmd_word       = '0;
      cmd_word.cmd   = vbd_pkg::vbd_cmd_code_type'(req_cmd);
      cmd_word.solid = req_solid;
      cmd_word.light = req_light;
      if (cmd_word.cmd == vbd_pkg::CMD_READ) begin
         // A read addresses the word at the first corner as given.
         cmd_word.y_lo = ya;
         cmd_word.y_hi = ya;
         cmd_word.z_lo = za;
         cmd_word.z_hi = za;
      end else begin
         cmd_word.y_lo = (ya <= yb) ? ya : yb;
         cmd_word.y_hi = (ya <= yb) ? yb : ya;
         cmd_word.z_lo = (za <= zb) ? za : zb;
         cmd_word.z_hi = (za <= zb) ? zb : za;
      end
      for (int i = 0; i < W; i++) begin
         cmd_word.x_mask[i] = (CW'(i) >= x_lo) && (CW'(i) <= x_hi);
      end
      cmd_word.end_mask = (W'(1) << x_lo) | (W'(1) << x_hi);
   end

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;
   assign q_data    = cmd_word;

endmodule

// ===== design/vbd_queue.sv =====
// ----------------------------------------------------------------------------
// vbd_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module vbd_queue #(
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output logic [DATA_W-1:0] pop_data
);

   localparam int DEPTH = 2;
   localparam int PW    = $clog2(DEPTH);
   localparam int NW    = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == NW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? PW'(wr_ptr_ff + PW'(1)) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? PW'(rd_ptr_ff + PW'(1)) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = NW'(count_ff + NW'(1));
      end else if (do_pop && !do_push) begin
         count_in = NW'(count_ff - NW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/vbd_back.sv =====
// ----------------------------------------------------------------------------
// vbd_back
// Back end: owns the voxel store, walks the y/z span of a draw with a
// pipelined read-modify-write (one word per cycle) and serves word reads
// into the registered result stage.
// ----------------------------------------------------------------------------
module vbd_back #(
   parameter int CUBE_SIZE = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  logic [3+4*$clog2(CUBE_SIZE)+2*CUBE_SIZE-1:0] q_data,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_row_bits
);

   localparam int CW    = $clog2(CUBE_SIZE);
   localparam int W     = CUBE_SIZE;
   localparam int DEPTH = CUBE_SIZE * CUBE_SIZE;
   localparam int AW    = $clog2(DEPTH);

   typedef struct packed {
      vbd_pkg::vbd_cmd_code_type cmd;
      logic                      solid;
      logic                      light;
      logic [CW-1:0]             y_lo;
      logic [CW-1:0]             y_hi;
      logic [CW-1:0]             z_lo;
      logic [CW-1:0]             z_hi;
      logic [W-1:0]              x_mask;
      logic [W-1:0]              end_mask;
   } vbd_cmd_type;

   function automatic logic [AW-1:0] word_addr(input logic [CW-1:0] y,
                                                input logic [CW-1:0] z);
      word_addr = AW'(AW'(y) * AW'(CUBE_SIZE) + AW'(z));
   endfunction

   vbd_cmd_type                 q_cmd;
   vbd_pkg::vbd_back_state_type state_ff, state_in;
   vbd_cmd_type                 cmd_ff, cmd_in;
   logic [CW-1:0]               y_ff, y_in, z_ff, z_in;

   logic [W-1:0]                mem [DEPTH];
   logic [DEPTH-1:0]            vld_ff;
   logic                        rd_en;
   logic [AW-1:0]               rd_addr;
   logic [W-1:0]                rd_data_ff;
   logic                        rd_vld_ff;

   logic                        wr_pend_ff, wr_pend_in;
   logic [AW-1:0]               wr_addr_ff, wr_addr_in;
   logic [W-1:0]                wr_mask_ff, wr_mask_in;
   logic [W-1:0]                old_word, wr_data;

   logic                        rd_pend_ff, rd_pend_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [7:0]                  rsp_bits_ff;
   logic [7:0]                  row8;

   logic                        y_edge, z_edge;
   logic [W-1:0]                walk_mask;

   assign q_cmd = q_data;

   // Mask for the word at the current walk position.
   always_comb begin
      y_edge = (y_ff == cmd_ff.y_lo) || (y_ff == cmd_ff.y_hi);
      z_edge = (z_ff == cmd_ff.z_lo) || (z_ff == cmd_ff.z_hi);
      if (cmd_ff.solid || (y_edge && z_edge)) begin
         walk_mask = cmd_ff.x_mask;
      end else if (y_edge || z_edge) begin
         walk_mask = cmd_ff.end_mask;
      end else begin
         walk_mask = '0;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      y_in       = y_ff;
      z_in       = z_ff;
      q_pop      = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = word_addr(y_ff, z_ff);
      wr_pend_in = 1'b0;
      wr_addr_in = wr_addr_ff;
      wr_mask_in = wr_mask_ff;
      rd_pend_in = 1'b0;
      case (state_ff)
         vbd_pkg::BK_IDLE: begin
            // A new command waits for the last write and the last read to land.
            if (q_valid && !wr_pend_ff && !rd_pend_ff) begin
               if (q_cmd.cmd == vbd_pkg::CMD_READ) begin
                  if (!rsp_valid_ff || rsp_ready) begin
                     q_pop      = 1'b1;
                     rd_en      = 1'b1;
                     rd_addr    = word_addr(q_cmd.y_lo, q_cmd.z_lo);
                     rd_pend_in = 1'b1;
                  end
               end else begin
                  q_pop    = 1'b1;
                  cmd_in   = q_cmd;
                  y_in     = q_cmd.y_lo;
                  z_in     = q_cmd.z_lo;
                  state_in = vbd_pkg::BK_WALK;
               end
            end
         end
         vbd_pkg::BK_WALK: begin
            rd_en      = 1'b1;
            wr_pend_in = 1'b1;
            wr_addr_in = word_addr(y_ff, z_ff);
            wr_mask_in = walk_mask;
            if (z_ff == cmd_ff.z_hi) begin
               z_in = cmd_ff.z_lo;
               if (y_ff == cmd_ff.y_hi) begin
                  state_in = vbd_pkg::BK_IDLE;
               end else begin
                  y_in = CW'(y_ff + CW'(1));
               end
            end else begin
               z_in = CW'(z_ff + CW'(1));
            end
         end
         default: begin
            state_in = vbd_pkg::BK_IDLE;
         end
      endcase
   end

   // Second half of the read-modify-write; a never-written word reads as dark.
   assign old_word = rd_vld_ff ? rd_data_ff : '0;
   assign wr_data  = cmd_ff.light ? (old_word | wr_mask_ff) : (old_word & ~wr_mask_ff);

   generate
      if (W >= 8) begin : g_row_trim
         assign row8 = old_word[7:0];
      end else begin : g_row_pad
         assign row8 = {{(8 - W){1'b0}}, old_word};
      end
   endgenerate

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rd_pend_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vbd_pkg::BK_IDLE;
         wr_pend_ff   <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         wr_pend_ff   <= wr_pend_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_pend_ff) begin
            vld_ff[wr_addr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      y_ff       <= y_in;
      z_ff       <= z_in;
      wr_addr_ff <= wr_addr_in;
      wr_mask_ff <= wr_mask_in;
      if (rd_pend_ff) begin
         rsp_bits_ff <= row8;
      end
   end

   // Voxel store: one read port and one write port, registered read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
      end
      if (wr_pend_ff) begin
         mem[wr_addr_ff] <= wr_data;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_row_bits = rsp_bits_ff;

`ifndef ASSERT_OFF
   a_read_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> !rsp_valid_ff)
      else $error("read data arrived while the result stage was still full");

   a_read_not_during_write: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> !wr_pend_ff)
      else $error("word read overlapped a pending store write");

   a_walk_writes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vbd_pkg::BK_WALK) |=> wr_pend_ff)
      else $error("walk step did not schedule its write");

   a_pop_when_quiet: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> ((state_ff == vbd_pkg::BK_IDLE) && !wr_pend_ff && !rd_pend_ff))
      else $error("command taken while earlier work was still in flight");
`endif

endmodule

// ===== design/voxel_box_draw_unit.sv =====
// ----------------------------------------------------------------------------
// voxel_box_draw_unit
// Axis-aligned box rasteriser over a CUBE_SIZE^3 voxel frame buffer.
// ----------------------------------------------------------------------------
// Usage. Commands arrive as beats on the req_ channel (valid/ready). A draw
// beat (req_cmd = draw) sets or clears a solid or wireframe box between two
// corners and returns nothing. A read beat returns the stored word at
// (req_y_first, req_z_first) as one beat on the rsp_ channel; bit x of
// rsp_row_bits is voxel x. Coordinates beyond the cube saturate to the last
// plane.
// Flow. The front end classifies a beat in the cycle it is
// accepted and queues it in a two-entry queue. The back end walks a draw one
// store word per cycle through a pipelined read-modify-write on the store's
// read and write ports. A read is queued like a draw, and the back end takes
// no new command until the last write and the last read have landed.
// Reset. The synchronous reset darkens the whole cube at once through
// per-word valid bits; there is no clearing pass, and the block takes beats
// as soon as reset is released.
// Stalls. A result waits in an output register while rsp_ready is low. Draws
// ahead of the next read still run, but that read waits at the head of the
// queue; further beats are queued until the queue is full, then req_ready
// drops. No result is ever dropped or overwritten.
// ----------------------------------------------------------------------------
module voxel_box_draw_unit #(
   parameter int CUBE_SIZE = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_cmd,
   input  logic [2:0] req_x_first,
   input  logic [2:0] req_y_first,
   input  logic [2:0] req_z_first,
   input  logic [2:0] req_x_second,
   input  logic [2:0] req_y_second,
   input  logic [2:0] req_z_second,
   input  logic       req_solid,
   input  logic       req_light,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_row_bits
);

   // Packed command: code, solid, light, four span ends and two x masks.
   localparam int CMD_W = 3 + 4 * $clog2(CUBE_SIZE) + 2 * CUBE_SIZE;

   logic             q_full;
   logic             q_push;
   logic [CMD_W-1:0] q_push_data;
   logic             q_pop;
   logic             q_valid;
   logic [CMD_W-1:0] q_data;

   // Front end: clamp, sort and mask building for each accepted beat.
   vbd_front #(
      .CUBE_SIZE (CUBE_SIZE)
   ) u_front (
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_x_first  (req_x_first),
      .req_y_first  (req_y_first),
      .req_z_first  (req_z_first),
      .req_x_second (req_x_second),
      .req_y_second (req_y_second),
      .req_z_second (req_z_second),
      .req_solid    (req_solid),
      .req_light    (req_light),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_data       (q_push_data)
   );

   // The queue lets the front keep accepting while the back end walks a box.
   vbd_queue #(
      .DATA_W (CMD_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   // Back end: voxel store, span walker and result register.
   vbd_back #(
      .CUBE_SIZE (CUBE_SIZE)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_data       (q_data),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_row_bits (rsp_row_bits)
   );

endmodule

// ===== dv/tb_voxel_box_draw_unit.sv =====
// ----------------------------------------------------------------------------
// tb_voxel_box_draw_unit
// Self-checking testbench for the voxel box draw unit.
// ----------------------------------------------------------------------------
// A shadow copy of the 8x8x8 cube is painted with every accepted draw beat. Each
// accepted read beat queues the word that the shadow holds at that moment, and
// every returned beat is checked against the oldest queued word. The stimulus
// has three parts. A short directed set covers full-cube boxes, flat and point
// boxes and swapped corners. A long random stream follows, mixing reads with
// draws whose spans are mostly short. A final sweep reads back all 64 words.
// ----------------------------------------------------------------------------
module tb_voxel_box_draw_unit;
   timeunit 1ns;
   timeprecision 1ps;

   // One request beat, laid out field by field as on the req_ ports.
   typedef struct packed {
      vbd_pkg::vbd_cmd_code_type cmd;
      logic [2:0]                x_first;
      logic [2:0]                y_first;
      logic [2:0]                z_first;
      logic [2:0]                x_second;
      logic [2:0]                y_second;
      logic [2:0]                z_second;
      logic                      solid;
      logic                      light;
   } voxel_cmd_type;

   // Shadow cube plus the rows that reads have yet to return.
   class voxel_scoreboard;
      logic [7:0] shadow_cube [64];
      logic [7:0] awaited_rows [$];
      int fail_count;
      int solid_draws;
      int wire_draws;
      int clear_draws;
      int rows_checked;

      function new();
         foreach (shadow_cube[i]) shadow_cube[i] = 8'h00;
         fail_count   = 0;
         solid_draws  = 0;
         wire_draws   = 0;
         clear_draws  = 0;
         rows_checked = 0;
      endfunction

      function int waiting();
         return awaited_rows.size();
      endfunction

      // Coordinates are three bits wide and the cube is eight voxels on a side,
      // so saturation at the far face never comes into play here.
      function void note_request(voxel_cmd_type c);
         int xl, xh, yl, yh, zl, zh;
         logic [7:0] span_mask;
         logic [7:0] end_mask;
         logic [7:0] m;
         bit on_y, on_z;
         if (c.cmd == vbd_pkg::CMD_READ) begin
            awaited_rows.push_back(shadow_cube[{c.y_first, c.z_first}]);
            return;
         end
         xl = int'((c.x_first < c.x_second) ? c.x_first : c.x_second);
         xh = int'((c.x_first < c.x_second) ? c.x_second : c.x_first);
         yl = int'((c.y_first < c.y_second) ? c.y_first : c.y_second);
         yh = int'((c.y_first < c.y_second) ? c.y_second : c.y_first);
         zl = int'((c.z_first < c.z_second) ? c.z_first : c.z_second);
         zh = int'((c.z_first < c.z_second) ? c.z_second : c.z_first);
         span_mask = (8'hFF << xl) & (8'hFF >> (7 - xh));
         end_mask  = (8'h01 << xl) | (8'h01 << xh);
         for (int y = yl; y <= yh; y++) begin
            for (int z = zl; z <= zh; z++) begin
               on_y = (y == yl) || (y == yh);
               on_z = (z == zl) || (z == zh);
               if (c.solid || (on_y && on_z)) m = span_mask;
               else if (on_y || on_z) m = end_mask;
               else m = 8'h00;
               if (c.light) shadow_cube[y * 8 + z] |= m;
               else shadow_cube[y * 8 + z] &= ~m;
            end
         end
         if (c.solid) solid_draws++;
         else wire_draws++;
         if (!c.light) clear_draws++;
      endfunction

      function void check_row(logic [7:0] row);
         logic [7:0] want;
         if (awaited_rows.size() == 0) begin
            $error("row_bits: beat with no read outstanding, actual 0x%02h", row);
            fail_count++;
            return;
         end
         want = awaited_rows.pop_front();
         rows_checked++;
         if (row !== want) begin
            $error("row_bits mismatch: expected 0x%02h, actual 0x%02h", want, row);
            fail_count++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_cmd = 1'b0;
   logic [2:0] req_x_first = 3'd0;
   logic [2:0] req_y_first = 3'd0;
   logic [2:0] req_z_first = 3'd0;
   logic [2:0] req_x_second = 3'd0;
   logic [2:0] req_y_second = 3'd0;
   logic [2:0] req_z_second = 3'd0;
   logic       req_solid = 1'b0;
   logic       req_light = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_row_bits;

   // Percentages of cycles in which the sender holds back a beat and the
   // receiver refuses one.
   int send_idle_pct = 0;
   int take_idle_pct = 0;

   voxel_scoreboard sb;

   voxel_box_draw_unit u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_x_first  (req_x_first),
      .req_y_first  (req_y_first),
      .req_z_first  (req_z_first),
      .req_x_second (req_x_second),
      .req_y_second (req_y_second),
      .req_z_second (req_z_second),
      .req_solid    (req_solid),
      .req_light    (req_light),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_row_bits (rsp_row_bits)
   );

   always #10 clock = ~clock;

   // The receiver decides afresh at every falling edge whether it will take a
   // beat, so that stalls land on every phase of a draw or a read.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= take_idle_pct);
   end

   // Returned beats are sampled at the rising edge, before the block updates.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_row(rsp_row_bits);
   end

   // Presents one beat at a falling edge, after a random number of idle
   // cycles, and holds it until the block accepts it at a rising edge.
   task automatic drive_beat(input voxel_cmd_type c);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= c.cmd;
      req_x_first  <= c.x_first;
      req_y_first  <= c.y_first;
      req_z_first  <= c.z_first;
      req_x_second <= c.x_second;
      req_y_second <= c.y_second;
      req_z_second <= c.z_second;
      req_solid    <= c.solid;
      req_light    <= c.light;
      do @(posedge clock); while (!req_ready);
      sb.note_request(c);
   endtask

   task automatic draw_box(input logic [2:0] x1, y1, z1, x2, y2, z2,
                           input logic solid, light);
      voxel_cmd_type c;
      c = '{vbd_pkg::CMD_DRAW, x1, y1, z1, x2, y2, z2, solid, light};
      drive_beat(c);
   endtask

   // A read ignores every field but the y and z of the word, so the others
   // are filled with noise.
   task automatic read_word(input logic [2:0] y, z);
      voxel_cmd_type c;
      logic [20:0] noise;
      noise = 21'($urandom);
      c = noise;
      c.cmd = vbd_pkg::CMD_READ;
      c.y_first = y;
      c.z_first = z;
      drive_beat(c);
   endtask

   // Mostly short spans, so that boxes stay small and the draws stay quick,
   // with the corners handed over in either order.
   function automatic logic [5:0] pick_span();
      int lo, hi;
      if ($urandom_range(99) < 80) begin
         lo = $urandom_range(7);
         hi = lo + $urandom_range(2);
         if (hi > 7) hi = 7;
      end else begin
         lo = $urandom_range(7);
         hi = $urandom_range(7);
      end
      if ($urandom_range(1)) return {3'(lo), 3'(hi)};
      return {3'(hi), 3'(lo)};
   endfunction

   task automatic random_beats(input int count);
      logic [5:0] xs, ys, zs;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 45) begin
            read_word(3'($urandom_range(7)), 3'($urandom_range(7)));
         end else begin
            xs = pick_span();
            ys = pick_span();
            zs = pick_span();
            draw_box(xs[5:3], ys[5:3], zs[5:3], xs[2:0], ys[2:0], zs[2:0],
                     1'($urandom_range(1)), 1'($urandom_range(1)));
         end
      end
   endtask

   // Lowers valid and waits until every read has been answered, or until
   // the cycle limit runs out.
   task automatic wait_drained(input int limit);
      int spent;
      spent = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.waiting() != 0 && spent < limit) begin
         @(posedge clock);
         spent++;
      end
   endtask

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Sender idles now and then, while the receiver stalls often.
      send_idle_pct = 11;
      take_idle_pct = 46;

      // The cube must come out of reset dark.
      read_word(3'd0, 3'd0);
      read_word(3'd7, 3'd7);
      // Fill the whole cube, then clear its wire frame with the corners given
      // high first. Corner words empty, edge words lose both end bits, and
      // the inner words keep everything.
      draw_box(3'd0, 3'd0, 3'd0, 3'd7, 3'd7, 3'd7, 1'b1, 1'b1);
      read_word(3'd7, 3'd0);
      draw_box(3'd7, 3'd7, 3'd7, 3'd0, 3'd0, 3'd0, 1'b0, 1'b0);
      read_word(3'd0, 3'd0);
      read_word(3'd0, 3'd3);
      read_word(3'd3, 3'd3);
      draw_box(3'd0, 3'd0, 3'd0, 3'd7, 3'd7, 3'd7, 1'b1, 1'b0);
      // A wire box that is flat in y: the whole plane is boundary.
      draw_box(3'd5, 3'd4, 3'd6, 3'd2, 3'd4, 3'd1, 1'b0, 1'b1);
      read_word(3'd4, 3'd1);
      read_word(3'd4, 3'd3);
      // Flat in z and as wide as the cube in x and y.
      draw_box(3'd0, 3'd7, 3'd2, 3'd7, 3'd0, 3'd2, 1'b0, 1'b1);
      read_word(3'd3, 3'd2);
      read_word(3'd0, 3'd2);
      // A single voxel in the far corner.
      draw_box(3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 3'd7, 1'b0, 1'b1);
      read_word(3'd7, 3'd7);
      // A solid box only one voxel deep in x.
      draw_box(3'd0, 3'd3, 3'd6, 3'd0, 3'd1, 3'd5, 1'b1, 1'b1);
      read_word(3'd2, 3'd5);
      // A wire clear strictly inside the cube leaves its inner words alone.
      draw_box(3'd1, 3'd1, 3'd1, 3'd6, 3'd6, 3'd6, 1'b1, 1'b1);
      draw_box(3'd6, 3'd1, 3'd6, 3'd1, 3'd6, 3'd1, 1'b0, 1'b0);
      read_word(3'd3, 3'd3);
      read_word(3'd1, 3'd4);
      read_word(3'd1, 3'd1);

      random_beats(575);

      // Hold the sender back until the block has answered every read.
      wait_drained(100000);
      send_idle_pct = 46;
      take_idle_pct = 11;
      random_beats(575);

      wait_drained(100000);
      send_idle_pct = 0;
      take_idle_pct = 0;
      random_beats(575);

      // Read back the whole cube so that the last draws are seen as well.
      for (int y = 0; y < 8; y++) begin
         for (int z = 0; z < 8; z++) read_word(3'(y), 3'(z));
      end

      wait_drained(5000);
      if (sb.waiting() != 0) begin
         $error("row_bits: %0d reads never answered", sb.waiting());
         sb.fail_count++;
      end
      // A long draw can hold the block while two more wait queued behind it,
      // so give any stray beat time to show itself.
      repeat (250) @(posedge clock);

      $display("Covered %0d solid and %0d wire draws (%0d of them clearing) and %0d reads,",
               sb.solid_draws, sb.wire_draws, sb.clear_draws, sb.rows_checked);
      $display("under sender-light, receiver-light and stall-free traffic.");
      if (sb.fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Backstop for a block that hangs.
   initial begin
      #15_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
